### rtl/stpr_pkg.sv
// ----------------------------------------------------------------------------
// stpr_pkg
// Shared types and constants for the stepper trapezoid ramp unit.
// ----------------------------------------------------------------------------
package stpr_pkg;

  localparam int POS_W    = 32;
  localparam int DELAY_W  = 12;
  localparam int CIDX_W   = 2;
  localparam int CDATA_W  = 12;
  localparam int OUT_W    = 40;

  localparam logic [CIDX_W-1:0] CFG_START_DELAY = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_RAMP_STEPS  = 2'd1;

  localparam logic [DELAY_W-1:0] START_DELAY_RST = 12'd900;
  localparam logic [DELAY_W-1:0] RAMP_STEPS_RST  = 12'd800;
  localparam logic [DELAY_W-1:0] DELAY_MAX       = 12'd4095;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_TARGET = 1'b1;

  typedef struct packed {
    logic [DELAY_W-1:0] start_delay;
    logic [DELAY_W-1:0] ramp_steps;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             busy_res;
    logic             direction_level;
    logic             step_pulse;
  } res_t;

endpackage

### rtl/stepper_trapezoid_ramp_unit.sv
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp_unit
// One stepper axis: trapezoidal step timing, one word per tick or command.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser opcode, tdata target_position
//  m_*      out  m_tvalid/m_tready  tdata pulse, dir, busy, position
//  cfg_*    in   cfg_valid/ready    cfg_index, cfg_data (12 bit)
//
// Each result is computed combinationally from its input word and registered.
// Throughput is one word per cycle while no skidded word holds s_tready low.
// An output register and a one-word skid absorb m_tready stalls; s_tready
// drops while a skidded word waits.
// rst is synchronous; config returns to start_delay 900, ramp_steps 800.
// ----------------------------------------------------------------------------
module stepper_trapezoid_ramp_unit
  import stpr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [POS_W-1:0]   s_tdata,   // [31:0] target_position
  input  logic               s_tuser,   // [0] opcode
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_W-1:0]   m_tdata,   // [0] step_pulse, [1] direction_level,
                                        // [2] busy_res, [34:3] position, [39:35] zero
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data
);

  cfg_t cfg;
  res_t res;
  res_t out_word, skid_word;
  logic out_valid, skid_valid;
  logic accept, out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = ~skid_valid;
  assign accept    = s_tvalid & s_tready;
  assign out_free  = ~out_valid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_delay <= START_DELAY_RST;
      cfg.ramp_steps  <= RAMP_STEPS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_DELAY: cfg.start_delay <= cfg_data;
        CFG_RAMP_STEPS:  cfg.ramp_steps  <= cfg_data;
        default: ;
      endcase
    end
  end

  stpr_core u_core (
    .clk             (clk),
    .rst             (rst),
    .en              (accept),
    .opcode          (s_tuser),
    .target_position (s_tdata),
    .cfg             (cfg),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (accept) begin
        out_word <= res;
      end
    end else if (accept) begin
      skid_word <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_W - $bits(res_t)){1'b0}}, out_word};

endmodule

### rtl/stpr_core.sv
// ----------------------------------------------------------------------------
// stpr_core
// Ramp state and per-word update: target latch, move start, step timing.
// ----------------------------------------------------------------------------
module stpr_core
  import stpr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             opcode,
  input  logic [POS_W-1:0] target_position,
  input  cfg_t             cfg,
  output res_t             res
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_UP     = 2'd1,
    PH_CRUISE = 2'd2,
    PH_DOWN   = 2'd3
  } phase_t;

  phase_t             phase, phase_next;
  logic [POS_W-1:0]   position_reg, position_reg_next;
  logic [POS_W-1:0]   target_reg, target_reg_next;
  logic [POS_W-1:0]   steps_left, steps_left_next;
  logic [POS_W-1:0]   tail_steps, tail_steps_next;
  logic [DELAY_W-1:0] down_steps, down_steps_next;
  logic [DELAY_W-1:0] current_delay, current_delay_next;
  logic [DELAY_W-1:0] tick_count, tick_count_next;
  logic               pulse_high, pulse_high_next;
  logic               dir_reg, dir_reg_next;

  logic [POS_W:0]     diff;
  logic [POS_W-1:0]   neg_diff;
  logic [POS_W-1:0]   move_dist;
  logic               long_move;

  assign diff     = {target_reg[POS_W-1], target_reg} - {position_reg[POS_W-1], position_reg};
  assign neg_diff = position_reg - target_reg;
  assign move_dist = diff[POS_W] ? neg_diff : diff[POS_W-1:0];
  assign long_move = move_dist >= {{(POS_W-DELAY_W-1){1'b0}}, cfg.ramp_steps, 1'b0};

  always_comb begin
    phase_next         = phase;
    position_reg_next  = position_reg;
    target_reg_next    = target_reg;
    steps_left_next    = steps_left;
    tail_steps_next    = tail_steps;
    down_steps_next    = down_steps;
    current_delay_next = current_delay;
    tick_count_next    = tick_count;
    pulse_high_next    = pulse_high;
    dir_reg_next       = dir_reg;
    if (en) begin
      if (opcode == OP_TARGET) begin
        target_reg_next = target_position;
      end else if (phase == PH_IDLE) begin
        if (position_reg != target_reg) begin
          dir_reg_next    = diff[POS_W];
          steps_left_next = move_dist;
          if (long_move) begin
            tail_steps_next = move_dist - {{(POS_W-DELAY_W){1'b0}}, cfg.ramp_steps};
            down_steps_next = cfg.ramp_steps;
          end else begin
            tail_steps_next = {1'b0, move_dist[POS_W-1:1]};
            down_steps_next = move_dist[DELAY_W:1];
          end
          current_delay_next = (cfg.start_delay == '0) ? DELAY_W'(1) : cfg.start_delay;
          pulse_high_next    = 1'b1;
          tick_count_next    = DELAY_W'(1);
          // zero-length ramps go straight to cruise
          phase_next = (long_move && cfg.ramp_steps == '0) ? PH_CRUISE : PH_UP;
        end
      end else if (pulse_high) begin
        if (tick_count < current_delay) begin
          tick_count_next = tick_count + DELAY_W'(1);
        end else begin
          pulse_high_next   = 1'b0;
          position_reg_next = dir_reg ? position_reg - POS_W'(1) : position_reg + POS_W'(1);
          steps_left_next   = steps_left - POS_W'(1);
          if (phase == PH_UP && current_delay > DELAY_W'(1)) begin
            current_delay_next = current_delay - DELAY_W'(1);
          end else if (phase == PH_DOWN && current_delay < DELAY_MAX) begin
            current_delay_next = current_delay + DELAY_W'(1);
          end
          if (steps_left == POS_W'(1)) begin
            phase_next = PH_IDLE;
          end
        end
      end else begin
        pulse_high_next = 1'b1;
        tick_count_next = DELAY_W'(1);
        if (steps_left > tail_steps) begin
          phase_next = PH_UP;
        end else if (steps_left > {{(POS_W-DELAY_W){1'b0}}, down_steps}) begin
          phase_next = PH_CRUISE;
        end else begin
          phase_next = PH_DOWN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      position_reg  <= '0;
      target_reg    <= '0;
      steps_left    <= '0;
      tail_steps    <= '0;
      down_steps    <= '0;
      current_delay <= '0;
      tick_count    <= '0;
      pulse_high    <= 1'b0;
      dir_reg       <= 1'b0;
    end else begin
      phase         <= phase_next;
      position_reg  <= position_reg_next;
      target_reg    <= target_reg_next;
      steps_left    <= steps_left_next;
      tail_steps    <= tail_steps_next;
      down_steps    <= down_steps_next;
      current_delay <= current_delay_next;
      tick_count    <= tick_count_next;
      pulse_high    <= pulse_high_next;
      dir_reg       <= dir_reg_next;
    end
  end

  assign res.step_pulse      = pulse_high_next;
  assign res.direction_level = dir_reg_next;
  assign res.busy_res        = (phase_next != PH_IDLE);
  assign res.position        = position_reg_next;

endmodule

### rtl/stpr_checker.sv
// ----------------------------------------------------------------------------
// stpr_checker
// Port-level checks on the stepper trapezoid ramp unit.
// ----------------------------------------------------------------------------
module stpr_checker
  import stpr_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               s_tuser,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [OUT_W-1:0]   m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word dropped or changed while stalled");

  a_pulse_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[2])
    else $error("step pulse high outside a move");

  a_reset_state: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("buffer not empty after reset");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == OP_TARGET && m_tvalid && m_tready
    |=> m_tvalid)
    else $error("command word produced no result");

endmodule

bind stepper_trapezoid_ramp_unit stpr_checker u_stpr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives tick and new-target words into the stepper ramp unit under a range
// of start delays and ramp lengths, predicts every result word from its own
// model of the axis and compares the output stream field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import stpr_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int CALM_FROM    = 1500;
  localparam int CALM_TO      = 4500;

  typedef enum logic [1:0] {MV_IDLE, MV_UP, MV_CRUISE, MV_DOWN} move_phase_t;

  typedef struct {
    logic             op;
    logic [POS_W-1:0] val;
  } axis_cmd_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [POS_W-1:0]   s_tdata = '0;
  logic               s_tuser = OP_TICK;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CIDX_W-1:0]  cfg_index = CFG_START_DELAY;
  logic [CDATA_W-1:0] cfg_data = '0;

  stepper_trapezoid_ramp_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // axis model state
  logic [DELAY_W-1:0] cf_start = START_DELAY_RST;
  logic [DELAY_W-1:0] cf_ramp  = RAMP_STEPS_RST;
  logic [POS_W-1:0]   ax_pos    = '0;
  logic [POS_W-1:0]   ax_tgt    = '0;
  logic [POS_W-1:0]   ax_left   = '0;
  logic [POS_W-1:0]   ax_cruise = '0;
  logic [DELAY_W-1:0] ax_down   = '0;
  logic [DELAY_W-1:0] ax_delay  = '0;
  logic [DELAY_W-1:0] ax_count  = '0;
  logic               ax_pulse  = 1'b0;
  logic               ax_dir    = 1'b0;
  move_phase_t        ax_phase  = MV_IDLE;

  axis_cmd_t pending_cmds[$];
  res_t      due_results[$];
  int        faults = 0;
  int        words_in = 0;
  int        words_out = 0;
  int        moves_begun = 0;
  int        settings_run = 1;
  int        cyc = 0;

  task automatic launch_step();
    ax_pulse = 1'b1;
    ax_count = DELAY_W'(1);
    if ({1'b0, ax_left} > {1'b0, ax_cruise} + {21'd0, ax_down})
      ax_phase = MV_UP;
    else if (ax_left > {20'd0, ax_down})
      ax_phase = MV_CRUISE;
    else
      ax_phase = MV_DOWN;
  endtask

  task automatic step_axis(input logic op, input logic [POS_W-1:0] val, output res_t r);
    logic [32:0] diff;
    logic [32:0] move_dist;
    logic [32:0] twice;
    if (op == OP_TARGET) begin
      ax_tgt = val;
    end else if (ax_phase == MV_IDLE) begin
      if (ax_pos != ax_tgt) begin
        diff = {ax_tgt[31], ax_tgt} - {ax_pos[31], ax_pos};
        ax_dir = diff[32];
        move_dist = diff[32] ? -diff : diff;
        twice = {20'd0, cf_ramp, 1'b0};
        if (move_dist >= twice) begin
          ax_cruise = move_dist[31:0] - twice[31:0];
          ax_down = cf_ramp;
        end else begin
          ax_cruise = '0;
          ax_down = move_dist[12:1];
        end
        ax_left = move_dist[31:0];
        ax_delay = (cf_start == 0) ? DELAY_W'(1) : cf_start;
        moves_begun++;
        launch_step();
      end
    end else if (ax_pulse) begin
      if (ax_count < ax_delay) begin
        ax_count = ax_count + 1'b1;
      end else begin
        ax_pulse = 1'b0;
        ax_pos = ax_dir ? ax_pos - 1 : ax_pos + 1;
        ax_left = ax_left - 1;
        if (ax_phase == MV_UP && ax_delay > 1)
          ax_delay = ax_delay - 1'b1;
        else if (ax_phase == MV_DOWN && ax_delay < DELAY_MAX)
          ax_delay = ax_delay + 1'b1;
        if (ax_left == 0)
          ax_phase = MV_IDLE;
      end
    end else begin
      launch_step();
    end
    r.step_pulse = ax_pulse;
    r.direction_level = ax_dir;
    r.busy_res = (ax_phase != MV_IDLE);
    r.position = ax_pos;
  endtask

  function automatic logic calm();
    return cyc >= CALM_FROM && cyc < CALM_TO;
  endfunction

  // sender
  always @(posedge clk) begin
    axis_cmd_t c;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_cmds.size() != 0 && (calm() || $urandom_range(99) >= 19)) begin
        c = pending_cmds.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= c.op;
        s_tdata <= c.val;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    m_tready <= calm() || $urandom_range(99) >= 19;
  end

  // monitor and checker
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START_DELAY: cf_start = cfg_data;
          CFG_RAMP_STEPS:  cf_ramp = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        step_axis(s_tuser, s_tdata, want);
        due_results.push_back(want);
        words_in++;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[34:0];
        words_out++;
        if (due_results.size() == 0) begin
          $error("result word with nothing expected: %h", m_tdata);
          faults++;
        end else begin
          want = due_results.pop_front();
          if (got.step_pulse !== want.step_pulse) begin
            $error("step_pulse: expected %0d, got %0d", want.step_pulse, got.step_pulse);
            faults++;
          end
          if (got.direction_level !== want.direction_level) begin
            $error("direction_level: expected %0d, got %0d", want.direction_level,
                   got.direction_level);
            faults++;
          end
          if (got.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
            faults++;
          end
          if (got.position !== want.position) begin
            $error("position: expected %0d, got %0d", $signed(want.position),
                   $signed(got.position));
            faults++;
          end
          if (m_tdata[OUT_W-1:35] !== '0) begin
            $error("pad: expected 0, got %0h", m_tdata[OUT_W-1:35]);
            faults++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cyc);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic push_cmd(input logic op, input logic [POS_W-1:0] val);
    axis_cmd_t c;
    c.op = op;
    c.val = val;
    pending_cmds.push_back(c);
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_cmd(OP_TICK, $urandom);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || s_tvalid || due_results.size() != 0);
  endtask

  // tick on until the axis stands at its target
  task automatic settle();
    drain();
    while (ax_phase != MV_IDLE || ax_pos != ax_tgt) begin
      push_ticks(64);
      drain();
    end
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_ramp(input logic [DELAY_W-1:0] start, input logic [DELAY_W-1:0] ramp);
    repeat (3) @(posedge clk);
    write_reg(CFG_START_DELAY, start);
    write_reg(CFG_RAMP_STEPS, ramp);
    settings_run++;
  endtask

  // random moves around the current position, some noise targets overridden
  task automatic roam(input int words);
    int n;
    int len;
    logic [POS_W-1:0] base;
    n = 0;
    base = ax_pos;
    while (n < words) begin
      if ($urandom_range(9) != 0) begin
        if ($urandom_range(3) == 0) begin
          push_cmd(OP_TARGET, $urandom);
          n++;
        end
        push_cmd(OP_TARGET, base + $urandom_range(60) - 30);
        n++;
      end
      len = $urandom_range(60, 2);
      push_ticks(len);
      n += len;
    end
  endtask

  logic [DELAY_W-1:0] starts[8] = '{12'd3, 12'd1, 12'd6, 12'd12, 12'd2, 12'd7, 12'd5, 12'd1};
  logic [DELAY_W-1:0] ramps[8]  = '{12'd2, 12'd0, 12'd4095, 12'd5, 12'd1, 12'd3, 12'd12, 12'd9};

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: target extremes, left at zero so nothing moves
    push_cmd(OP_TARGET, 32'h7FFF_FFFF);
    push_cmd(OP_TARGET, 32'h8000_0000);
    push_cmd(OP_TARGET, 32'hFFFF_FFFF);
    push_cmd(OP_TARGET, 32'h0000_0000);
    push_ticks(3);
    settle();

    // zero start delay, ramp held at the one-tick floor, target changed mid-move
    set_ramp(12'd0, 12'd2);
    push_cmd(OP_TARGET, 32'hFFFF_FFFF);
    push_ticks(3);
    push_cmd(OP_TARGET, 32'd3);
    push_ticks(3);
    push_cmd(OP_TARGET, 32'hFFFF_FFFE);
    push_ticks(9);
    settle();

    // single step at a long delay, full-length ramp setting
    set_ramp(12'd120, 12'd4095);
    push_cmd(OP_TARGET, ax_pos + 1);
    settle();

    for (int i = 0; i < 8; i++) begin
      set_ramp(starts[i], ramps[i]);
      roam(100);
      settle();
    end

    // move far beyond what the run can finish
    set_ramp(12'd2, 12'd3);
    push_cmd(OP_TARGET, ax_pos[31] ? 32'h7FFF_FFFF : 32'h8000_0000);
    push_ticks(60);
    push_cmd(OP_TARGET, 32'd0);
    push_ticks(20);
    drain();
    repeat (20) @(posedge clk);

    $display("%0d words in, %0d results out, %0d moves begun under %0d ramp settings",
             words_in, words_out, moves_begun, settings_run);
    if (faults == 0 && due_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
